[rtl/core/channel_line_demux_parser_unit_assert.svh]
// Assertion macros for the channel line demultiplexer.
`ifndef CHANNEL_LINE_DEMUX_PARSER_UNIT_ASSERT_SVH
`define CHANNEL_LINE_DEMUX_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CHLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chld assertion failed");
`define CHLD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chld assertion failed");
`else
`define CHLD_ASSERT_IMP(lbl, ante, cons)
`define CHLD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/chld_pkg.sv]
// Shared constants, types and helper functions of the channel line demultiplexer.
package chld_pkg;

  localparam int CHANNELS       = 8;
  localparam int RESPONSE_DEPTH = 1024;
  localparam int CHANNEL_DEPTH  = 1024;

  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RESP_FILL_W = $clog2(RESPONSE_DEPTH + 1);
  localparam int CHAN_FILL_W = $clog2(CHANNEL_DEPTH + 1);
  localparam int INDEX_W     = 10;
  localparam int CHANNEL_W   = 3;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;

  typedef enum logic [1:0] {
    ST_NORMAL,
    ST_HEADER,
    ST_CHANNEL,
    ST_INVALID
  } parse_state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                 to_channel;
    logic [CHANNEL_W-1:0] channel;
    logic [7:0]           out_byte;
    logic [INDEX_W-1:0]   write_index;
    logic                 last_write;
  } out_item_t;

  typedef struct packed {
    logic      r0_vld;
    logic      r1_vld;
    out_item_t r0;
    out_item_t r1;
  } result_pair_t;

  typedef struct packed {
    logic [1:0] count;
    logic       room;
  } obuf_status_t;

  function automatic logic [INDEX_W-1:0] resp_index(input logic [RESP_FILL_W-1:0] f);
    logic [RESP_FILL_W+INDEX_W-1:0] e;
    e = {{INDEX_W{1'b0}}, f};
    return e[INDEX_W-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] chan_index(input logic [CHAN_FILL_W-1:0] f);
    logic [CHAN_FILL_W+INDEX_W-1:0] e;
    e = {{INDEX_W{1'b0}}, f};
    return e[INDEX_W-1:0];
  endfunction

  function automatic logic [CHANNEL_W-1:0] chan_field(input logic [CH_W-1:0] c);
    logic [CH_W+CHANNEL_W-1:0] e;
    e = {{CHANNEL_W{1'b0}}, c};
    return e[CHANNEL_W-1:0];
  endfunction

endpackage

[rtl/core/channel_line_demux_parser_unit.sv]
// Top level of the channel line demultiplexer.
// Takes one request per cycle while in_stall is low: a received byte or a
// flush. Each byte passes an input register, is parsed combinationally and
// lands in a two-entry result register, so its first result is offered once
// it has passed both the input register and the result register. A byte
// yields at most one result, except a newline not followed by a colon,
// where the newline and the byte both go to the response buffer; that pair
// fills both result entries and holds the input off until the second one
// is leaving. Sustained rate is one request per cycle while no pair forms
// and results leave one per cycle, set by the single result port.
// Flush returns the parser to normal data and clears every fill count.
`include "channel_line_demux_parser_unit_assert.svh"

module channel_line_demux_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chld_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output chld_pkg::out_item_t out_data
);

  chld_pkg::in_item_t     parse_item;
  logic                   parse_take;
  chld_pkg::result_pair_t res;
  chld_pkg::obuf_status_t obuf_st;
  logic                   flush_take;

  assign flush_take = parse_take && (parse_item.action == chld_pkg::ACT_FLUSH);

  chld_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (obuf_st.room),
    .take     (parse_take),
    .item     (parse_item)
  );

  chld_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (parse_take),
    .item  (parse_item),
    .res   (res)
  );

  chld_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (parse_take),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (obuf_st)
  );

  `CHLD_ASSERT_IMP(a_pair_head_not_last, obuf_st.count == 2'd2, !out_data.last_write)
  `CHLD_ASSERT_IMP(a_single_is_last, obuf_st.count == 2'd1, out_data.last_write)
  `CHLD_ASSERT_NXT(a_flush_no_result, flush_take, obuf_st.count == 2'd0)

endmodule

[rtl/core/chld_in_reg.sv]
// Input register stage that holds one request until the parser takes it.
module chld_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chld_pkg::in_item_t  in_data,
  input  logic                room,
  output logic                take,
  output chld_pkg::in_item_t  item
);

  logic               vld_r;
  logic               vld_nxt;
  chld_pkg::in_item_t item_r;
  logic               load;

  assign take     = vld_r && room;
  assign in_stall = vld_r && !room;
  assign load     = in_valid && !in_stall;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

[rtl/core/chld_parser.sv]
// Header parser, fill counters and result formation for one byte.
module chld_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  chld_pkg::in_item_t     item,
  output chld_pkg::result_pair_t res
);

  chld_pkg::parse_state_t state_r, state_nxt;
  logic [2:0]                         hcount_r, hcount_nxt;
  logic [7:0]                         hch_r, hch_nxt;
  logic [7:0]                         hsep_r, hsep_nxt;
  logic [chld_pkg::CH_W-1:0]          cur_r, cur_nxt;
  logic [chld_pkg::RESP_FILL_W-1:0]   resp_fill_r, resp_fill_nxt;
  logic [chld_pkg::CHAN_FILL_W-1:0]   chan_fill_r [chld_pkg::CHANNELS];
  logic [chld_pkg::CHAN_FILL_W-1:0]   chan_fill_nxt [chld_pkg::CHANNELS];

  logic [8:0]                         diff;
  logic                               hdr_ok;
  logic [chld_pkg::CH_W-1:0]          digit;
  logic [chld_pkg::CH_W-1:0]          rd_ch;
  logic [chld_pkg::CHAN_FILL_W-1:0]   cfill;
  logic                               chan_ok;
  logic                               resp_ok;
  logic                               resp_ok2;
  logic [chld_pkg::RESP_FILL_W:0]     resp_plus1;
  logic                               chan_store;
  logic                               resp_store;
  logic                               lf_pair;
  logic [7:0]                         b;

  assign b      = item.data_byte;
  assign diff   = {1'b0, hch_r} - {1'b0, chld_pkg::CHAR_ZERO};
  assign hdr_ok = !diff[8] && (diff < 9'(chld_pkg::CHANNELS)) &&
                  (hsep_r == chld_pkg::CHAR_SPACE);
  assign digit  = diff[chld_pkg::CH_W-1:0];

  // A header decision stores into the newly chosen channel, so the one
  // fill-count read follows the channel that the store will use.
  assign rd_ch   = (state_r == chld_pkg::ST_HEADER) ? digit : cur_r;
  assign cfill   = chan_fill_r[rd_ch];
  assign chan_ok = cfill < chld_pkg::CHAN_FILL_W'(chld_pkg::CHANNEL_DEPTH);

  assign resp_ok    = resp_fill_r < chld_pkg::RESP_FILL_W'(chld_pkg::RESPONSE_DEPTH);
  assign resp_plus1 = {1'b0, resp_fill_r} + 1'b1;
  assign resp_ok2   = resp_plus1 < (chld_pkg::RESP_FILL_W + 1)'(chld_pkg::RESPONSE_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    hcount_nxt    = hcount_r;
    hch_nxt       = hch_r;
    hsep_nxt      = hsep_r;
    cur_nxt       = cur_r;
    resp_fill_nxt = resp_fill_r;
    chan_fill_nxt = chan_fill_r;
    chan_store    = 1'b0;
    resp_store    = 1'b0;
    lf_pair       = 1'b0;
    res           = '0;

    if (item.action == chld_pkg::ACT_FLUSH) begin
      state_nxt     = chld_pkg::ST_NORMAL;
      hcount_nxt    = 3'd0;
      resp_fill_nxt = '0;
      for (int i = 0; i < chld_pkg::CHANNELS; i++) begin
        chan_fill_nxt[i] = '0;
      end
    end else begin
      unique case (state_r)
        chld_pkg::ST_HEADER: begin
          if (hcount_r == 3'd1) begin
            if (b != chld_pkg::CHAR_COLON) begin
              lf_pair   = 1'b1;
              state_nxt = chld_pkg::ST_NORMAL;
            end else begin
              hcount_nxt = 3'd2;
            end
          end else if (hcount_r >= 3'd4) begin
            if (hdr_ok) begin
              cur_nxt    = digit;
              state_nxt  = chld_pkg::ST_CHANNEL;
              chan_store = 1'b1;
            end else begin
              state_nxt = chld_pkg::ST_INVALID;
            end
          end else begin
            if (hcount_r == 3'd2) begin
              hch_nxt = b;
            end else if (hcount_r == 3'd3) begin
              hsep_nxt = b;
            end
            hcount_nxt = hcount_r + 3'd1;
          end
        end
        chld_pkg::ST_CHANNEL, chld_pkg::ST_INVALID: begin
          if (b == chld_pkg::CHAR_CR) begin
            state_nxt = chld_pkg::ST_NORMAL;
          end else if (state_r == chld_pkg::ST_CHANNEL) begin
            chan_store = 1'b1;
          end
        end
        chld_pkg::ST_NORMAL: begin
          if (b == chld_pkg::CHAR_LF) begin
            hcount_nxt = 3'd1;
            state_nxt  = chld_pkg::ST_HEADER;
          end else begin
            resp_store = 1'b1;
          end
        end
        default: begin
          state_nxt = chld_pkg::ST_NORMAL;
        end
      endcase
    end

    if (chan_store && chan_ok) begin
      res.r0_vld            = 1'b1;
      res.r0.to_channel     = 1'b1;
      res.r0.channel        = chld_pkg::chan_field(rd_ch);
      res.r0.out_byte       = b;
      res.r0.write_index    = chld_pkg::chan_index(cfill);
      res.r0.last_write     = 1'b1;
      chan_fill_nxt[rd_ch]  = cfill + 1'b1;
    end

    if (resp_store && resp_ok) begin
      res.r0_vld         = 1'b1;
      res.r0.out_byte    = b;
      res.r0.write_index = chld_pkg::resp_index(resp_fill_r);
      res.r0.last_write  = 1'b1;
      resp_fill_nxt      = resp_plus1[chld_pkg::RESP_FILL_W-1:0];
    end

    // Missing colon: the held-back newline goes first, then this byte, each
    // subject to the response buffer limit.
    if (lf_pair && resp_ok) begin
      res.r0_vld         = 1'b1;
      res.r0.out_byte    = chld_pkg::CHAR_LF;
      res.r0.write_index = chld_pkg::resp_index(resp_fill_r);
      res.r0.last_write  = !resp_ok2;
      resp_fill_nxt      = resp_plus1[chld_pkg::RESP_FILL_W-1:0];
      if (resp_ok2) begin
        res.r1_vld         = 1'b1;
        res.r1.out_byte    = b;
        res.r1.write_index = chld_pkg::resp_index(resp_plus1[chld_pkg::RESP_FILL_W-1:0]);
        res.r1.last_write  = 1'b1;
        resp_fill_nxt      = resp_plus1[chld_pkg::RESP_FILL_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chld_pkg::ST_NORMAL;
      hcount_r    <= 3'd0;
      hch_r       <= 8'd0;
      hsep_r      <= 8'd0;
      cur_r       <= '0;
      resp_fill_r <= '0;
      for (int i = 0; i < chld_pkg::CHANNELS; i++) begin
        chan_fill_r[i] <= '0;
      end
    end else if (take) begin
      state_r     <= state_nxt;
      hcount_r    <= hcount_nxt;
      hch_r       <= hch_nxt;
      hsep_r      <= hsep_nxt;
      cur_r       <= cur_nxt;
      resp_fill_r <= resp_fill_nxt;
      chan_fill_r <= chan_fill_nxt;
    end
  end

endmodule

[rtl/core/chld_out_buf.sv]
// Two-entry result register that drains one result per cycle while out_stall is low.
module chld_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  chld_pkg::result_pair_t res,
  output logic                   out_valid,
  input  logic                   out_stall,
  output chld_pkg::out_item_t    out_data,
  output chld_pkg::obuf_status_t status
);

  logic [1:0]          cnt_r, cnt_nxt;
  chld_pkg::out_item_t s0_r, s0_nxt;
  chld_pkg::out_item_t s1_r, s1_nxt;
  logic                drain;

  assign out_valid    = (cnt_r != 2'd0);
  assign out_data     = s0_r;
  assign drain        = out_valid && !out_stall;
  assign status.count = cnt_r;
  // A new result pair may land only when both slots are free by the edge.
  assign status.room  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && drain);

  always_comb begin
    cnt_nxt = cnt_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (load) begin
      cnt_nxt = {1'b0, res.r0_vld} + {1'b0, res.r1_vld};
      s0_nxt  = res.r0;
      s1_nxt  = res.r1;
    end else if (drain) begin
      if (cnt_r == 2'd2) begin
        s0_nxt  = s1_r;
        cnt_nxt = 2'd1;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

endmodule
